FILE: sv/crlfd_pkg.sv
// Shared constants and types for the CRLF-framed pose deframer.
package crlfd_pkg;

   // Framing bytes
   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharLf = 8'h0A;

   // Payload geometry
   localparam int unsigned PayloadLen = 24;
   localparam int unsigned WordCount  = 6;
   localparam int unsigned IndexWidth = 5;

   // One decoded pose frame, six little-endian float bit patterns
   typedef struct packed {
      logic [31:0] z_angle_bits;
      logic [31:0] x_angle_bits;
      logic [31:0] y_angle_bits;
      logic [31:0] pos_x_bits;
      logic [31:0] pos_y_bits;
      logic [31:0] yaw_rate_bits;
   } pose_type;

   // Parser status toward the top level
   typedef struct packed {
      logic                  frame_done;
      logic [IndexWidth-1:0] payload_index;
   } parse_status_type;

endpackage

FILE: sv/crlfd_parser.sv
// Frame parser: header/trailer state machine and payload byte store.
module crlfd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_transfer,
   input  logic [7:0]                  rx_byte,
   output crlfd_pkg::parse_status_type status,
   output crlfd_pkg::pose_type         pose
);

   typedef enum logic [2:0] {
      HUNT_CR   = 3'd0,
      EXPECT_LF = 3'd1,
      COLLECT   = 3'd2,
      TRAIL_LF  = 3'd3,
      TRAIL_CR  = 3'd4
   } phase_type;

   localparam logic [crlfd_pkg::IndexWidth-1:0] LastIndex =
      crlfd_pkg::IndexWidth'(crlfd_pkg::PayloadLen - 1);

   phase_type                          phase_ff, phase_in;
   logic [crlfd_pkg::IndexWidth-1:0]   index_ff, index_in;
   logic                               store_shift;
   logic [7:0]                         payload_ff [crlfd_pkg::PayloadLen];

   // Next phase and payload count per received byte
   always_comb begin
      phase_in    = phase_ff;
      index_in    = index_ff;
      store_shift = 1'b0;
      if (byte_transfer) begin
         case (phase_ff)
            HUNT_CR: begin
               phase_in = (rx_byte == crlfd_pkg::CharCr) ? EXPECT_LF : HUNT_CR;
            end
            EXPECT_LF: begin
               if (rx_byte == crlfd_pkg::CharLf) begin
                  index_in = '0;
                  phase_in = COLLECT;
               end else if (rx_byte != crlfd_pkg::CharCr) begin
                  phase_in = HUNT_CR;
               end
            end
            COLLECT: begin
               if (index_ff < LastIndex) begin
                  store_shift = 1'b1;
                  index_in    = index_ff + 1'b1;
               end else begin
                  // last payload byte, or a count that should never get here
                  store_shift = (index_ff == LastIndex);
                  index_in    = '0;
                  phase_in    = TRAIL_LF;
               end
            end
            TRAIL_LF: begin
               phase_in = (rx_byte == crlfd_pkg::CharLf) ? TRAIL_CR : HUNT_CR;
            end
            TRAIL_CR: begin
               phase_in = HUNT_CR;
            end
            default: begin
               phase_in = HUNT_CR;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT_CR;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   // Payload store: bytes shift down so the first byte ends at entry 0
   always_ff @(posedge clock) begin
      if (store_shift) begin
         for (int i = 0; i < crlfd_pkg::PayloadLen - 1; i++) begin
            payload_ff[i] <= payload_ff[i+1];
         end
         payload_ff[crlfd_pkg::PayloadLen-1] <= rx_byte;
      end
   end

   // Good trailer completes on this byte
   assign status.frame_done = byte_transfer && (phase_ff == TRAIL_CR) &&
                              (rx_byte == crlfd_pkg::CharCr);
   assign status.payload_index = index_ff;

   // Little-endian word assembly
   assign pose.z_angle_bits  = {payload_ff[3],  payload_ff[2],  payload_ff[1],  payload_ff[0]};
   assign pose.x_angle_bits  = {payload_ff[7],  payload_ff[6],  payload_ff[5],  payload_ff[4]};
   assign pose.y_angle_bits  = {payload_ff[11], payload_ff[10], payload_ff[9],  payload_ff[8]};
   assign pose.pos_x_bits    = {payload_ff[15], payload_ff[14], payload_ff[13], payload_ff[12]};
   assign pose.pos_y_bits    = {payload_ff[19], payload_ff[18], payload_ff[17], payload_ff[16]};
   assign pose.yaw_rate_bits = {payload_ff[23], payload_ff[22], payload_ff[21], payload_ff[20]};

endmodule

FILE: sv/crlf_framed_pose_deframer_top.sv
// Top level of the CRLF-framed pose deframer with its result register.
//
// Usage:
//   The req_ channel carries one received serial byte per transfer. The
//   parser hunts for CR LF (extra CRs before the LF are fine), collects 24
//   payload bytes and checks for the trailer LF CR. A frame with a good
//   trailer produces one rsp_ transfer of six 32-bit float bit patterns,
//   assembled little-endian from the payload. Bad framing drops the frame
//   and the parser resumes hunting; no result is produced for it.
//   Throughput: one byte per cycle while req_stall is low; the frame-done
//   decode is combinational logic in front of the result register.
//   Latency: the result is valid the cycle after the closing CR transfer
//   when the result register is free.
//   Stall: a result that completes while the result register is held by
//   rsp_stall waits in a spare register and moves up once the held result
//   is taken. req_stall is high only while the spare is occupied.
//   Reset: synchronous; the parser returns to hunting and both result
//   registers empty. Payload bytes are not cleared.
module crlf_framed_pose_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_z_angle_bits,
   output logic [31:0] rsp_x_angle_bits,
   output logic [31:0] rsp_y_angle_bits,
   output logic [31:0] rsp_pos_x_bits,
   output logic [31:0] rsp_pos_y_bits,
   output logic [31:0] rsp_yaw_rate_bits
);

   logic                        req_transfer;
   crlfd_pkg::parse_status_type status;
   crlfd_pkg::pose_type         pose;
   crlfd_pkg::pose_type         pose_ff;
   crlfd_pkg::pose_type         spare_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        spare_valid_ff, spare_valid_in;
   logic                        load_out;
   logic                        load_from_spare;
   logic                        load_spare;

   // Input side waits only while the spare register is occupied
   assign req_stall    = spare_valid_ff;
   assign req_transfer = req_valid && !req_stall;

   crlfd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_transfer (req_transfer),
      .rx_byte       (req_rx_byte),
      .status        (status),
      .pose          (pose)
   );

   // Result register and spare: spare drains first, new frames go behind it
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      spare_valid_in  = spare_valid_ff;
      load_out        = 1'b0;
      load_from_spare = 1'b0;
      load_spare      = 1'b0;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (spare_valid_ff) begin
            load_from_spare = 1'b1;
            rsp_valid_in    = 1'b1;
            spare_valid_in  = 1'b0;
         end else begin
            load_out     = status.frame_done;
            rsp_valid_in = status.frame_done;
         end
      end else if (status.frame_done) begin
         load_spare     = 1'b1;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_from_spare) begin
         pose_ff <= spare_ff;
      end else if (load_out) begin
         pose_ff <= pose;
      end
      if (load_spare) begin
         spare_ff <= pose;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_z_angle_bits  = pose_ff.z_angle_bits;
   assign rsp_x_angle_bits  = pose_ff.x_angle_bits;
   assign rsp_y_angle_bits  = pose_ff.y_angle_bits;
   assign rsp_pos_x_bits    = pose_ff.pos_x_bits;
   assign rsp_pos_y_bits    = pose_ff.pos_y_bits;
   assign rsp_yaw_rate_bits = pose_ff.yaw_rate_bits;

`ifndef NO_ASSERTIONS
   // A new result only follows a transferred closing CR
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_transfer && req_rx_byte == crlfd_pkg::CharCr))
      else $error("result appeared without a closing CR transfer");

   // Payload count stays inside the store
   assert property (@(posedge clock) disable iff (reset)
      status.payload_index < crlfd_pkg::IndexWidth'(crlfd_pkg::PayloadLen))
      else $error("payload index out of range");

   // A completed frame always leaves the count at zero
   assert property (@(posedge clock) disable iff (reset)
      status.frame_done |-> status.payload_index == '0)
      else $error("frame completed with payload count not cleared");

   // The spare is only used behind a held result and is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> rsp_valid_ff && !status.frame_done)
      else $error("spare result register misused");
`endif

endmodule
